// ----- hw/rtl/u8sd_pkg.sv -----
// ----------------------------------------------------------------------------
// u8sd_pkg: shared types and constants of the UTF-8 stream decoder
// Widths of the byte and code point paths, the queue depth default and the
// job record that the front end hands to the back end.
// ----------------------------------------------------------------------------
package u8sd_pkg;

	localparam int BYTE_W      = 8;
	localparam int CP_W        = 21;
	localparam int MAX_RESULTS = 4;
	localparam int CNT_W       = 3;
	localparam int QUEUE_DEPTH = 4;

	// One accepted byte that releases code points turns into one job: up to four code points in order.
	typedef struct packed {
		logic [CNT_W-1:0]                 cnt;
		logic [MAX_RESULTS-1:0][CP_W-1:0] cp;
	} job_t;

endpackage

// ----- hw/rtl/u8sd_front.sv -----
// ----------------------------------------------------------------------------
// u8sd_front: byte classifier and sequence tracker
// Classifies each accepted byte, tracks the open multi-byte sequence and
// builds the list of code points that the byte releases.
// ----------------------------------------------------------------------------
module u8sd_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [u8sd_pkg::BYTE_W-1:0]    in_byte,
	output logic                           push,
	output u8sd_pkg::job_t                 job
);

	localparam logic [7:0] ASCII_LIM = 8'h80;
	localparam logic [7:0] MASK_E0   = 8'hE0;
	localparam logic [7:0] MASK_C0   = 8'hC0;
	localparam logic [7:0] MASK_F0   = 8'hF0;
	localparam logic [7:0] MASK_F8   = 8'hF8;
	localparam logic [7:0] CONT_TAG  = 8'h80;
	localparam logic [7:0] PAY_1F    = 8'h1F;
	localparam logic [7:0] PAY_0F    = 8'h0F;
	localparam logic [7:0] PAY_07    = 8'h07;

	localparam int CP_W  = u8sd_pkg::CP_W;
	localparam int PAD_W = u8sd_pkg::CP_W - u8sd_pkg::BYTE_W;

	logic [7:0]      pend_q [3];
	logic [1:0]      pcount_q, pcount_d;
	logic [1:0]      need_q, need_d, need_n;
	logic [CP_W-1:0] partial_q, partial_d, shifted;
	logic            pend_we;
	logic [1:0]      pend_idx;
	logic [1:0]      fc;
	logic            fresh_vld;
	logic [CP_W-1:0] fresh_cp;
	logic            is_cont;

	assign is_cont = (in_byte & MASK_C0) == CONT_TAG;
	assign shifted = {partial_q[CP_W-7:0], in_byte[5:0]};
	assign need_n  = (need_q != 2'd0) ? need_q - 2'd1 : 2'd0;

	always_comb begin
		pcount_d  = pcount_q;
		need_d    = need_q;
		partial_d = partial_q;
		pend_we   = 1'b0;
		pend_idx  = 2'd0;
		fc        = 2'd0;
		fresh_vld = 1'b0;
		fresh_cp  = '0;
		if (pcount_q != 2'd0 && is_cont) begin
			if (need_n == 2'd0) begin
				fresh_vld = 1'b1;
				fresh_cp  = shifted;
				pcount_d  = 2'd0;
				need_d    = 2'd0;
				partial_d = '0;
			end else begin
				partial_d = shifted;
				need_d    = need_n;
				if (pcount_q < 2'd3) begin
					pend_we  = 1'b1;
					pend_idx = pcount_q;
					pcount_d = pcount_q + 2'd1;
				end
			end
		end else begin
			// Broken sequence or nothing open: flush what is buffered, then
			// decode this byte from scratch.
			fc        = pcount_q;
			pcount_d  = 2'd0;
			need_d    = 2'd0;
			partial_d = '0;
			if (in_byte == 8'h00) begin
				fresh_vld = 1'b0;
			end else if (in_byte < ASCII_LIM) begin
				fresh_vld = 1'b1;
				fresh_cp  = {{PAD_W{1'b0}}, in_byte};
			end else if ((in_byte & MASK_E0) == MASK_C0) begin
				partial_d = {{PAD_W{1'b0}}, in_byte & PAY_1F};
				need_d    = 2'd1;
				pend_we   = 1'b1;
				pcount_d  = 2'd1;
			end else if ((in_byte & MASK_F0) == MASK_E0) begin
				partial_d = {{PAD_W{1'b0}}, in_byte & PAY_0F};
				need_d    = 2'd2;
				pend_we   = 1'b1;
				pcount_d  = 2'd1;
			end else if ((in_byte & MASK_F8) == MASK_F0) begin
				partial_d = {{PAD_W{1'b0}}, in_byte & PAY_07};
				need_d    = 2'd3;
				pend_we   = 1'b1;
				pcount_d  = 2'd1;
			end else begin
				fresh_vld = 1'b1;
				fresh_cp  = {{PAD_W{1'b0}}, in_byte};
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			job.cp[k] = (2'(k) < fc) ? {{PAD_W{1'b0}}, pend_q[k]} : fresh_cp;
		end
		job.cp[3] = fresh_cp;
		job.cnt   = {1'b0, fc} + {2'b00, fresh_vld};
	end

	assign push = accept && (job.cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q  <= 2'd0;
			need_q    <= 2'd0;
			partial_q <= '0;
		end else if (accept) begin
			pcount_q  <= pcount_d;
			need_q    <= need_d;
			partial_q <= partial_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pend_we) begin
			pend_q[pend_idx] <= in_byte;
		end
	end

endmodule

// ----- hw/rtl/u8sd_queue.sv -----
// ----------------------------------------------------------------------------
// u8sd_queue: job queue between front end and back end
// A small register FIFO of jobs; it reports full and presents its head.
// ----------------------------------------------------------------------------
module u8sd_queue #(
	parameter int DEPTH = u8sd_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  u8sd_pkg::job_t wr_job,
	input  logic           pop,
	output logic           full,
	output logic           head_vld,
	output u8sd_pkg::job_t head_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	u8sd_pkg::job_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full     = count_q == CNT_W'(DEPTH);
	assign head_vld = count_q != '0;
	assign head_job = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && head_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

// ----- hw/rtl/u8sd_back.sv -----
// ----------------------------------------------------------------------------
// u8sd_back: result sequencer
// Walks the code points of the head job into the output register, one per
// cycle unless out_ready stalls it; retires the job with its last code point.
// ----------------------------------------------------------------------------
module u8sd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_vld,
	input  u8sd_pkg::job_t              head_job,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [u8sd_pkg::CP_W-1:0]   code_point,
	output logic                        last_of_run
);

	logic [1:0]                  idx_q;
	logic                        load, is_last;
	logic                        valid_q, last_q;
	logic [u8sd_pkg::CP_W-1:0]   cp_q;

	// The output register takes a new code point whenever it is empty or
	// its current one is being transferred.
	assign load    = head_vld && (!valid_q || out_ready);
	assign is_last = {1'b0, idx_q} == (head_job.cnt - 3'd1);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_q   <= head_job.cp[idx_q];
			last_q <= is_last;
		end
	end

	assign out_valid   = valid_q;
	assign code_point  = cp_q;
	assign last_of_run = last_q;

endmodule

// ----- hw/rtl/utf8_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_decoder: streaming UTF-8 to code point decoder
// Front end classifies bytes and tracks sequences, a job queue decouples it
// from the back end, which sends one code point per cycle unless stalled.
// ----------------------------------------------------------------------------
// The decoder takes one byte per cycle while in_ready is high and sends out
// one code point per cycle while out_ready is high; a byte that produces no
// code point uses no output slot. A byte that breaks a sequence releases up
// to four code points, which leave one per cycle, so the output port sets
// the sustained rate: bytes are decoded at one per cycle while they average
// at most one code point each and out_ready stays high. Jobs wait in a queue
// of QUEUE_DEPTH entries between the classifier and the output sequencer;
// in_ready falls only while that queue is full. Each code point passes
// through the job queue register and then the output register.
// ----------------------------------------------------------------------------
module utf8_stream_decoder #(
	parameter int QUEUE_DEPTH = u8sd_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [u8sd_pkg::BYTE_W-1:0] in_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [u8sd_pkg::CP_W-1:0]   code_point,
	output logic                        last_of_run
);

	logic           accept, push, pop, full, head_vld;
	u8sd_pkg::job_t wr_job, head_job;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	u8sd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (in_byte),
		.push    (push),
		.job     (wr_job)
	);

	u8sd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_job   (wr_job),
		.pop      (pop),
		.full     (full),
		.head_vld (head_vld),
		.head_job (head_job)
	);

	u8sd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_vld    (head_vld),
		.head_job    (head_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.code_point  (code_point),
		.last_of_run (last_of_run)
	);

endmodule

// ----- tb/utf8_stream_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_decoder_tb: self-checking testbench of the UTF-8 stream decoder
// A short table of directed bytes is followed by random text with well-formed,
// broken and terminated sequences. A code point model in the bench predicts
// every output not given in the table, and the output side checks each transfer
// in order. Both sides idle at random, and a long output hold-off fills the job queue.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_tb;

	localparam int BYTE_W      = u8sd_pkg::BYTE_W;
	localparam int CP_W        = u8sd_pkg::CP_W;
	localparam int MAX_RESULTS = u8sd_pkg::MAX_RESULTS;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 20;
	localparam int HOLD_CYCLES   = 80;
	localparam int PHASE_ITEMS   = 96;
	localparam int PRINT_LIMIT   = 100;

	localparam logic [7:0] LEAD2_MASK = 8'hE0, LEAD2_TAG = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0, LEAD3_TAG = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8, LEAD4_TAG = 8'hF0;

	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic            last;
	} cp_result_t;

	// One directed byte; where typed is set, the expected output is given here.
	typedef struct packed {
		logic [BYTE_W-1:0] b;
		logic              typed;
		logic              has_result;
		logic [CP_W-1:0]   cp;
	} byte_row_t;

	localparam int NUM_ROWS = 23;
	localparam byte_row_t BYTE_ROWS [NUM_ROWS] = '{
		'{8'h00, 1'b1, 1'b0, 21'h0},      // terminator with nothing pending
		'{8'h7F, 1'b1, 1'b1, 21'h7F},
		'{8'h80, 1'b1, 1'b1, 21'h80},     // stray continuation
		'{8'hF8, 1'b1, 1'b1, 21'hF8},
		'{8'hFF, 1'b1, 1'b1, 21'hFF},
		'{8'hC2, 1'b0, 1'b0, 21'h0},
		'{8'hA9, 1'b1, 1'b1, 21'hA9},
		'{8'hE2, 1'b0, 1'b0, 21'h0},
		'{8'h82, 1'b0, 1'b0, 21'h0},
		'{8'hAC, 1'b0, 1'b0, 21'h0},
		'{8'hF7, 1'b0, 1'b0, 21'h0},
		'{8'hBF, 1'b0, 1'b0, 21'h0},
		'{8'hBF, 1'b0, 1'b0, 21'h0},
		'{8'hBF, 1'b1, 1'b1, 21'h1FFFFF}, // largest four-byte value
		'{8'hF0, 1'b0, 1'b0, 21'h0},
		'{8'h9F, 1'b0, 1'b0, 21'h0},
		'{8'h98, 1'b0, 1'b0, 21'h0},
		'{8'h41, 1'b0, 1'b0, 21'h0},      // breaks a sequence of three bytes
		'{8'hE2, 1'b0, 1'b0, 21'h0},
		'{8'h00, 1'b0, 1'b0, 21'h0},      // terminator flushes the lead
		'{8'hC3, 1'b0, 1'b0, 21'h0},
		'{8'hC3, 1'b0, 1'b0, 21'h0},      // a lead breaks a lead
		'{8'hA9, 1'b0, 1'b0, 21'h0}
	};

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic [BYTE_W-1:0] in_byte     = '0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic [CP_W-1:0]   code_point;
	logic              last_of_run;

	cp_result_t expected_cps [$];
	int error_count   = 0;
	int cycle_count   = 0;
	int tx_idle_pct   = 0;
	int rx_idle_pct   = 0;
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;

	// Decoder model state.
	logic [BYTE_W-1:0] seq_bytes [3];
	logic [1:0]        seq_count = '0;
	logic [1:0]        seq_need  = '0;
	logic [CP_W-1:0]   seq_value = '0;
	logic [CP_W-1:0]   burst [MAX_RESULTS];
	int                burst_n;

	utf8_stream_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.code_point (code_point),
		.last_of_run(last_of_run)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [CP_W-1:0] got,
			input logic [CP_W-1:0] want);
		if (error_count < PRINT_LIMIT)
			$display("MISMATCH %s: got %h, expected %h", what, got, want);
		error_count++;
	endtask

	task automatic clear_sequence();
		seq_count = '0;
		seq_need  = '0;
		seq_value = '0;
	endtask

	task automatic start_fresh(input logic [BYTE_W-1:0] b);
		if (b == 8'h00) begin
			// The terminator has no code point of its own.
		end else if (b[7] == 1'b0) begin
			burst[burst_n] = CP_W'(b);
			burst_n++;
		end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
			seq_value    = CP_W'(b[4:0]);
			seq_need     = 2'd1;
			seq_bytes[0] = b;
			seq_count    = 2'd1;
		end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
			seq_value    = CP_W'(b[3:0]);
			seq_need     = 2'd2;
			seq_bytes[0] = b;
			seq_count    = 2'd1;
		end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
			seq_value    = CP_W'(b[2:0]);
			seq_need     = 2'd3;
			seq_bytes[0] = b;
			seq_count    = 2'd1;
		end else begin
			burst[burst_n] = CP_W'(b);
			burst_n++;
		end
	endtask

	// Advances the model by one byte; queues its code points when record is set.
	task automatic decode_byte(input logic [BYTE_W-1:0] b, input bit record,
			output int n);
		int k;
		burst_n = 0;
		if (seq_count != 0) begin
			if (b != 8'h00 && b[7:6] == 2'b10) begin
				seq_value = {seq_value[CP_W-7:0], b[5:0]};
				if (seq_need != 0)
					seq_need--;
				if (seq_need == 0) begin
					burst[burst_n] = seq_value;
					burst_n++;
					clear_sequence();
				end else if (seq_count < 3) begin
					seq_bytes[seq_count] = b;
					seq_count++;
				end
			end else begin
				// Broken sequence: buffered bytes go out raw, then b starts over.
				for (k = 0; k < seq_count; k++) begin
					burst[burst_n] = CP_W'(seq_bytes[k]);
					burst_n++;
				end
				clear_sequence();
				start_fresh(b);
			end
		end else begin
			start_fresh(b);
		end
		if (record)
			for (k = 0; k < burst_n; k++)
				expected_cps.push_back({burst[k], k == burst_n - 1});
		n = burst_n;
	endtask

	// Offers one byte and returns after the transfer, at a rising edge.
	task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed,
			input bit typed_has, input logic [CP_W-1:0] typed_cp, output int n);
		bit taken;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end
		decode_byte(b, !typed, n);
		if (typed && typed_has)
			expected_cps.push_back({typed_cp, 1'b1});
	endtask

	function automatic logic [BYTE_W-1:0] lead_byte(input int len);
		logic [7:0] r;
		r = 8'($urandom);
		case (len)
			2:       return {3'b110, r[4:0]};
			3:       return {4'b1110, r[3:0]};
			default: return {5'b11110, r[2:0]};
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] cont_byte();
		logic [7:0] r;
		r = 8'($urandom);
		return {2'b10, r[5:0]};
	endfunction

	// Sends one unit of random text and counts every byte it transfers.
	task automatic send_random_unit(inout int count);
		logic [BYTE_W-1:0] unit_bytes [$];
		logic [BYTE_W-1:0] b;
		int pick;
		int len;
		int k;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			len = $urandom_range(1, 4);
			if (len == 1)
				unit_bytes.push_back(8'($urandom_range(1, 127)));
			else begin
				unit_bytes.push_back(lead_byte(len));
				for (k = 1; k < len; k++)
					unit_bytes.push_back(cont_byte());
			end
		end else if (pick < 72) begin
			len = $urandom_range(2, 4);
			unit_bytes.push_back(lead_byte(len));
			for (k = $urandom_range(0, len - 2); k > 0; k--)
				unit_bytes.push_back(cont_byte());
			do
				b = 8'($urandom);
			while (b[7:6] == 2'b10);
			unit_bytes.push_back(b);
		end else if (pick < 82) begin
			unit_bytes.push_back(8'h00);
		end else begin
			unit_bytes.push_back(8'($urandom));
		end
		foreach (unit_bytes[i]) begin
			send_byte(unit_bytes[i], 1'b0, 1'b0, '0, n);
			count++;
		end
	endtask

	task automatic wait_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_cps.size() != 0)
			@(posedge clk);
	endtask

	// Output side: random stalls, plus a long hold-off on request.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left   <= HOLD_CYCLES;
			out_ready   <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Signals are stable at the falling edge, so a transfer seen here completes
	// at the next rising edge.
	always @(negedge clk) begin : check_output
		cp_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_cps.size() == 0) begin
				report_mismatch("code point with nothing expected", code_point, '0);
			end else begin
				want = expected_cps.pop_front();
				if (code_point !== want.cp)
					report_mismatch("code_point", code_point, want.cp);
				if (last_of_run !== want.last)
					report_mismatch("last_of_run", CP_W'(last_of_run), CP_W'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles, %0d code points outstanding",
				cycle_count, expected_cps.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin : stimulus
		int n;
		int phase_items;
		for (int k = 0; k < 3; k++)
			seq_bytes[k] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 11;
		rx_idle_pct = 75;
		for (int r = 0; r < NUM_ROWS; r++)
			send_byte(BYTE_ROWS[r].b, BYTE_ROWS[r].typed, BYTE_ROWS[r].has_result,
				BYTE_ROWS[r].cp, n);
		wait_until_drained();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 11;
					rx_idle_pct = 75;
				end
				1: begin
					tx_idle_pct = 75;
					rx_idle_pct = 11;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
					// The sender keeps offering bytes while the output is held.
					hold_requests <= hold_requests + 1;
				end
			endcase
			phase_items = 0;
			while (phase_items < PHASE_ITEMS)
				send_random_unit(phase_items);
			wait_until_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
